>>> design/css_pkg.sv
package css_pkg;

    localparam int NEEDLE_BYTES = 32;
    localparam int NEEDLE_WORDS = 4;
    localparam int LEN_BITS     = 6;
    localparam int START_BITS   = 16;
    localparam int APB_ADDR_W   = 6;
    localparam int APB_DATA_W   = 64;

    typedef enum logic [2:0] {
        REG_NEEDLE_LENGTH = 3'd0,
        REG_NEEDLE_WORD_0 = 3'd1,
        REG_NEEDLE_WORD_1 = 3'd2,
        REG_NEEDLE_WORD_2 = 3'd3,
        REG_NEEDLE_WORD_3 = 3'd4
    } t_reg_idx;

    typedef logic [NEEDLE_BYTES-1:0][7:0] t_needle;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctl;

    typedef struct packed {
        logic                  found;
        logic [START_BITS-1:0] match_start;
    } t_result;

    function automatic logic [7:0] fold_char(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

>>> design/css_if.sv
interface css_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       last_byte;

    modport source (output valid, output text_byte, output last_byte, input ready);
    modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

interface css_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [15:0] match_start;

    modport source (output valid, output found, output match_start, input ready);
    modport sink   (input valid, input found, input match_start, output ready);
endinterface

>>> design/css_cfg.sv
module css_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [css_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [css_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [css_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    output logic [css_pkg::LEN_BITS-1:0]    o_needle_length,
    output css_pkg::t_needle                o_needle
);
    import css_pkg::*;

    logic [LEN_BITS-1:0]   r_needle_length;
    logic [APB_DATA_W-1:0] r_word [NEEDLE_WORDS];
    logic                  wr_en;
    t_reg_idx              idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = t_reg_idx'(paddr[APB_ADDR_W-1:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_needle_length <= '0;
            for (int k = 0; k < NEEDLE_WORDS; k++) begin
                r_word[k] <= '0;
            end
        end else if (wr_en) begin
            case (idx)
                REG_NEEDLE_LENGTH: r_needle_length <= pwdata[LEN_BITS-1:0];
                REG_NEEDLE_WORD_0: r_word[0] <= pwdata;
                REG_NEEDLE_WORD_1: r_word[1] <= pwdata;
                REG_NEEDLE_WORD_2: r_word[2] <= pwdata;
                REG_NEEDLE_WORD_3: r_word[3] <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_NEEDLE_LENGTH: prdata = APB_DATA_W'(r_needle_length);
            REG_NEEDLE_WORD_0: prdata = r_word[0];
            REG_NEEDLE_WORD_1: prdata = r_word[1];
            REG_NEEDLE_WORD_2: prdata = r_word[2];
            REG_NEEDLE_WORD_3: prdata = r_word[3];
            default:           prdata = '0;
        endcase
    end

    assign o_needle_length = r_needle_length;
    assign o_needle        = {r_word[3], r_word[2], r_word[1], r_word[0]};

endmodule

>>> design/css_cell.sv
module css_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  css_pkg::t_cell_ctl i_ctl,
    input  logic               i_prev_hit,
    input  logic [7:0]         i_char,
    input  logic [7:0]         i_needle_byte,
    output logic               o_hit_next,
    output logic               o_hit
);
    import css_pkg::*;

    logic r_hit;
    logic n_hit;

    // Prefix through this byte matches if the shorter prefix matched through the previous compared byte.
    assign o_hit_next = i_prev_hit && (i_char == fold_char(i_needle_byte));

    always_comb begin
        n_hit = r_hit;
        if (i_ctl.clear) begin
            n_hit = 1'b0;
        end else if (i_ctl.shift) begin
            n_hit = o_hit_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else begin
            r_hit <= n_hit;
        end
    end

    assign o_hit = r_hit;

endmodule

>>> design/css_obuf.sv
module css_obuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  css_pkg::t_result  i_data,
    output logic              o_full,
    css_out_if.source         o_out
);
    import css_pkg::*;

    t_result    r_head;
    t_result    r_tail;
    logic [1:0] r_cnt;
    t_result    n_head;
    t_result    n_tail;
    logic [1:0] n_cnt;
    logic       pop;

    assign pop    = (r_cnt != 2'd0) && o_out.ready;
    assign o_full = (r_cnt == 2'd2);

    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        n_cnt  = r_cnt;
        if (i_push && pop) begin
            if (r_cnt == 2'd1) begin
                n_head = i_data;
            end else begin
                n_head = r_tail;
                n_tail = i_data;
            end
        end else if (i_push) begin
            if (r_cnt == 2'd0) begin
                n_head = i_data;
            end else begin
                n_tail = i_data;
            end
            n_cnt = r_cnt + 2'd1;
        end else if (pop) begin
            n_head = r_tail;
            n_cnt  = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_head <= n_head;
        r_tail <= n_tail;
    end

    assign o_out.valid       = (r_cnt != 2'd0);
    assign o_out.found       = r_head.found;
    assign o_out.match_start = r_head.match_start;

endmodule

>>> design/case_insensitive_substring_search.sv
// Case-insensitive substring search: text streams in one byte per beat and the
// block reports once per haystack, either found with the start index of the first
// occurrence of the needle (always found if it is empty), or not found on the last
// byte (or on a zero byte). Letters A-Z compare equal to a-z. The needle (up to
// MAX_NEEDLE bytes) and its length are set over the APB port, by the user only
// while the block is idle; the block does not enforce this. A row of MAX_NEEDLE
// cells holds one prefix-match bit each and passes it to the next cell on every
// compared byte, so the block takes one byte per clock. Each result is registered in
// a two-entry output buffer, and input stalls only when both entries are full.
module case_insensitive_substring_search #(
    parameter int MAX_NEEDLE    = 32,
    parameter int POSITION_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    css_in_if.sink                          i_text,
    css_out_if.source                       o_result,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [css_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [css_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [css_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import css_pkg::*;

    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

    logic [LEN_BITS-1:0]      needle_length;
    t_needle                  needle;
    logic [LEN_BITS-1:0]      len_eff;
    logic [7:0]               char_fold;
    logic                     accept;
    logic                     full;
    logic                     saturated;
    logic [POSITION_BITS-1:0] count;
    logic [POSITION_BITS-1:0] start_pos;
    logic [31:0]              start_wide;
    logic                     hit;
    logic                     push;
    t_result                  result;
    t_cell_ctl                cell_ctl;
    logic [MAX_NEEDLE-1:0]    hit_next;
    logic [MAX_NEEDLE-1:0]    hit_q;

    logic [POSITION_BITS-1:0] r_bytes_seen;
    logic                     r_reported;
    logic [POSITION_BITS-1:0] n_bytes_seen;
    logic                     n_reported;

    css_cfg u_cfg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_needle_length (needle_length),
        .o_needle        (needle)
    );

    assign len_eff = (needle_length > LEN_BITS'(MAX_NEEDLE)) ? LEN_BITS'(MAX_NEEDLE)
                                                              : needle_length;
    assign char_fold     = fold_char(i_text.text_byte);
    assign i_text.ready  = !full;
    assign accept        = i_text.valid && i_text.ready;

    // Cells shift only on a compared byte; last clears the row for the next haystack.
    assign cell_ctl.shift = accept && !r_reported && (len_eff != '0)
                            && (i_text.text_byte != 8'd0);
    assign cell_ctl.clear = accept && i_text.last_byte;

    for (genvar g = 0; g < MAX_NEEDLE; g++) begin : g_cell
        logic prev_hit;
        if (g == 0) begin : g_head
            assign prev_hit = 1'b1;
        end else begin : g_body
            assign prev_hit = hit_q[g-1];
        end
        css_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (cell_ctl),
            .i_prev_hit    (prev_hit),
            .i_char        (char_fold),
            .i_needle_byte (needle[g]),
            .o_hit_next    (hit_next[g]),
            .o_hit         (hit_q[g])
        );
    end

    // Full needle matched when the cell at depth len_eff reports a hit.
    always_comb begin
        hit = 1'b0;
        for (int k = 0; k < MAX_NEEDLE; k++) begin
            if (len_eff == LEN_BITS'(k + 1)) begin
                hit = hit_next[k];
            end
        end
    end

    assign saturated  = (r_bytes_seen == POS_MAX);
    assign count      = saturated ? POS_MAX : r_bytes_seen + POSITION_BITS'(1);
    assign start_pos  = saturated ? POS_MAX : count - POSITION_BITS'(len_eff);
    assign start_wide = 32'(start_pos);

    always_comb begin
        push                = 1'b0;
        result.found        = 1'b0;
        result.match_start  = '0;
        n_bytes_seen        = r_bytes_seen;
        n_reported          = r_reported;
        if (accept && !r_reported) begin
            if (len_eff == '0) begin
                push         = 1'b1;
                result.found = 1'b1;
            end else if (i_text.text_byte == 8'd0) begin
                push = 1'b1;
            end else begin
                if (hit) begin
                    push               = 1'b1;
                    result.found       = 1'b1;
                    result.match_start = start_wide[START_BITS-1:0];
                end else if (i_text.last_byte) begin
                    push = 1'b1;
                end
                n_bytes_seen = count;
            end
            if (push) begin
                n_reported = 1'b1;
            end
        end
        if (accept && i_text.last_byte) begin
            n_bytes_seen = '0;
            n_reported   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_seen <= '0;
            r_reported   <= 1'b0;
        end else begin
            r_bytes_seen <= n_bytes_seen;
            r_reported   <= n_reported;
        end
    end

    css_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (result),
        .o_full  (full),
        .o_out   (o_result)
    );

endmodule
